// ----- rtl/core/ecg_beat_rate_detector_core_macros.svh -----
// Assertion macros for the ECG beat/rate detector core.
// Expects clk and rst_n in the scope of every use; no other dependencies.
`ifndef ECG_BEAT_RATE_DETECTOR_CORE_MACROS_SVH
`define ECG_BEAT_RATE_DETECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define EBRD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define EBRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EBRD_ASSERT(lbl, ante, cons, msg)
`define EBRD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ebrd_pkg.sv -----
// Shared constants, register codes and unit control types for the beat/rate detector.
// No dependencies.
package ebrd_pkg;

    localparam int BASE_BITS     = 10;
    localparam int ALPHA_BITS    = 16;
    localparam int THR_BITS      = 32;
    localparam int LIMIT_BITS    = 16;
    localparam int GAIN_BITS     = 10;
    localparam int NUM_BITS      = 16;
    localparam int DERIV_BITS    = 32;
    localparam int RATE_BITS     = 16;
    localparam int CNT_BITS      = 16;
    localparam int MUL_B_BITS    = 16;
    localparam int MUL_LEN_BITS  = 5;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [BASE_BITS-1:0]  BASELINE_RST   = 10'd475;
    localparam logic [ALPHA_BITS-1:0] ALPHA_RST      = 16'd7313;
    localparam logic [THR_BITS-1:0]   THRESHOLD_RST  = 32'd800000;
    localparam logic [LIMIT_BITS-1:0] REFR_LIMIT_RST = 16'd100;
    localparam logic [GAIN_BITS-1:0]  GAIN_RST       = 10'd500;
    localparam logic [NUM_BITS-1:0]   RATE_NUM_RST   = 16'd30000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASELINE   = 3'd0,
        CFG_ALPHA      = 3'd1,
        CFG_THRESHOLD  = 3'd2,
        CFG_REFR_LIMIT = 3'd3,
        CFG_GAIN       = 3'd4,
        CFG_RATE_NUM   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                    start;
        logic [MUL_LEN_BITS-1:0] len;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

// ----- rtl/core/ebrd_mul.sv -----
// Serial shift-add multiplier: one multiplier bit per cycle, MSB first.
// Depends on ebrd_pkg (mul_ctl_t, unit_sts_t, MUL_B_BITS).
module ebrd_mul
    import ebrd_pkg::*;
#(
    parameter int A_BITS = 37
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mul_ctl_t                     ctl,
    input  logic [A_BITS-1:0]            a,
    input  logic [MUL_B_BITS-1:0]        b,   // operand left-aligned; len bits are used
    output logic [A_BITS+MUL_B_BITS-1:0] prod,
    output unit_sts_t                    sts
);

    localparam int P_BITS = A_BITS + MUL_B_BITS;

    logic [A_BITS-1:0]       a_reg;
    logic [MUL_B_BITS-1:0]   b_reg;
    logic [P_BITS-1:0]       acc_reg;
    logic [P_BITS-1:0]       acc_next;
    logic [MUL_LEN_BITS-1:0] cnt_reg;
    logic                    done_reg;

    assign acc_next = (acc_reg << 1) + (b_reg[MUL_B_BITS-1] ? P_BITS'(a_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                cnt_reg <= ctl.len;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - MUL_LEN_BITS'(1);
                done_reg <= (cnt_reg == MUL_LEN_BITS'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
        end
    end

    assign prod     = acc_reg;
    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;

endmodule

// ----- rtl/core/ebrd_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, for the heart-rate update.
// Depends on ebrd_pkg (unit_sts_t, NUM_BITS, CNT_BITS). Divisor must be nonzero.
module ebrd_div
    import ebrd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [CNT_BITS-1:0] den,
    output logic [NUM_BITS-1:0] quot,
    output unit_sts_t           sts
);

    localparam int DCNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0]  q_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]  den_reg;
    logic [DCNT_BITS-1:0] cnt_reg;
    logic                 done_reg;

    logic [CNT_BITS:0]    shifted;
    logic [CNT_BITS:0]    trial;
    logic                 fits;

    assign shifted = {rem_reg, q_reg[NUM_BITS-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= DCNT_BITS'(NUM_BITS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - DCNT_BITS'(1);
                done_reg <= (cnt_reg == DCNT_BITS'(1));
            end
        end
    end

    // dividend shifts out of q_reg as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? trial[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
            q_reg   <= {q_reg[NUM_BITS-2:0], fits};
        end
    end

    assign quot     = q_reg;
    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;

endmodule

// ----- rtl/core/ecg_beat_rate_detector_core.sv -----
// ECG beat/rate detector core: baseline removal, square, low-pass, derivative, beat, rate.
// Sequence per request: ST_IDLE takes the sample, then ST_SQ, ST_DIFF, ST_ALPHA, ST_DI,
// ST_GAIN, ST_CMP, ST_DIV on a beat only, and ST_OUT, paced by the shared serial
// multiplier (square, alpha, gain passes) and the serial divider.
// A new request is taken only in ST_IDLE, once the last result is loaded; a held output stalls it.
// rst_n is asynchronous: clears filter, counters and rate, loads register defaults.
module ecg_beat_rate_detector_core
    import ebrd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // [adc_sample]
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((DERIV_BITS+RATE_BITS+7)/8)*8-1:0] m_tdata, // [derivative, heart_rate]
    output logic [0:0]               m_tuser     // [beat]
);

`include "ecg_beat_rate_detector_core_macros.svh"

    localparam int MAG_BITS = (SAMPLE_BITS > BASE_BITS) ? SAMPLE_BITS : BASE_BITS;
    localparam int SQ_BITS  = 2 * MAG_BITS;
    localparam int INT_BITS = SQ_BITS + 1;
    localparam int F_BITS   = INT_BITS + FRAC_BITS;
    localparam int P_BITS   = F_BITS + MUL_B_BITS;
    localparam int OUT_W    = ((DERIV_BITS + RATE_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_DIFF,
        ST_ALPHA,
        ST_DI,
        ST_GAIN,
        ST_CMP,
        ST_DIV,
        ST_OUT
    } state_t;

    // configuration registers
    logic [BASE_BITS-1:0]  baseline_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [THR_BITS-1:0]   threshold_reg;
    logic [LIMIT_BITS-1:0] refr_limit_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [NUM_BITS-1:0]   rate_num_reg;

    // block state
    state_t                state_reg;
    logic [F_BITS-1:0]     filt_reg;
    logic [CNT_BITS-1:0]   samp_cnt_reg;
    logic [CNT_BITS-1:0]   refr_cnt_reg;
    logic [RATE_BITS-1:0]  rate_reg;

    // per-sample working registers
    logic [F_BITS-1:0]     x_reg;
    logic                  sign_reg;
    logic [INT_BITS-1:0]   old_int_reg;
    logic [DERIV_BITS-1:0] deriv_reg;
    logic                  beat_reg;

    // output register
    logic                  m_valid_reg;
    logic [DERIV_BITS-1:0] m_deriv_reg;
    logic [RATE_BITS-1:0]  m_rate_reg;
    logic                  m_beat_reg;

    logic [MAG_BITS-1:0]   samp_ext;
    logic [MAG_BITS-1:0]   base_ext;
    logic [MAG_BITS-1:0]   mag;
    logic [F_BITS-1:0]     x_next;
    logic                  x_ge;
    logic [F_BITS-1:0]     diff_abs;
    logic [F_BITS-1:0]     step;
    logic [F_BITS-1:0]     filt_next;
    logic [INT_BITS-1:0]   new_int;
    logic [INT_BITS-1:0]   di;
    logic [DERIV_BITS-1:0] deriv_next;
    logic [CNT_BITS-1:0]   samp_cnt_next;
    logic [CNT_BITS-1:0]   refr_cnt_next;
    logic                  beat_hit;

    mul_ctl_t              mul_ctl;
    logic [F_BITS-1:0]     mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    logic [P_BITS-1:0]     mul_prod;
    unit_sts_t             mul_sts;

    logic                  div_start;
    logic [NUM_BITS-1:0]   div_quot;
    unit_sts_t             div_sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg   <= BASELINE_RST;
            alpha_reg      <= ALPHA_RST;
            threshold_reg  <= THRESHOLD_RST;
            refr_limit_reg <= REFR_LIMIT_RST;
            gain_reg       <= GAIN_RST;
            rate_num_reg   <= RATE_NUM_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_BASELINE:   baseline_reg   <= cfg_wdata[BASE_BITS-1:0];
                CFG_ALPHA:      alpha_reg      <= cfg_wdata[ALPHA_BITS-1:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_wdata[THR_BITS-1:0];
                CFG_REFR_LIMIT: refr_limit_reg <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_GAIN:       gain_reg       <= cfg_wdata[GAIN_BITS-1:0];
                CFG_RATE_NUM:   rate_num_reg   <= cfg_wdata[NUM_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign samp_ext = MAG_BITS'(s_tdata[SAMPLE_BITS-1:0]);
    assign base_ext = MAG_BITS'(baseline_reg);
    assign mag      = (samp_ext >= base_ext) ? samp_ext - base_ext : base_ext - samp_ext;

    assign x_next   = F_BITS'(mul_prod[SQ_BITS-1:0]) << FRAC_BITS;
    assign x_ge     = (x_reg >= filt_reg);
    assign diff_abs = x_ge ? x_reg - filt_reg : filt_reg - x_reg;

    // alpha is Q0.16: keep the product's upper bits
    assign step      = mul_prod[ALPHA_BITS +: F_BITS];
    assign filt_next = sign_reg ? filt_reg - step : filt_reg + step;

    assign new_int = filt_reg[F_BITS-1:FRAC_BITS];
    assign di      = (new_int >= old_int_reg) ? new_int - old_int_reg : old_int_reg - new_int;

    assign deriv_next = (|mul_prod[P_BITS-1:DERIV_BITS]) ? '1 : mul_prod[DERIV_BITS-1:0];

    assign samp_cnt_next = (samp_cnt_reg == CNT_MAX) ? CNT_MAX : samp_cnt_reg + CNT_BITS'(1);
    assign refr_cnt_next = (refr_cnt_reg == CNT_MAX) ? CNT_MAX : refr_cnt_reg + CNT_BITS'(1);

    assign beat_hit  = (refr_cnt_reg >= refr_limit_reg) && (deriv_reg > threshold_reg);
    assign div_start = (state_reg == ST_CMP) && beat_hit;

    // multiplier request per pass: square, alpha scale, gain scale
    always_comb
    begin
        mul_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_ctl.start = s_tvalid;
                mul_ctl.len   = MUL_LEN_BITS'(MAG_BITS);
                mul_a         = F_BITS'(mag);
                mul_b         = MUL_B_BITS'(mag) << (MUL_B_BITS - MAG_BITS);
            end
            ST_DIFF:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.len   = MUL_LEN_BITS'(ALPHA_BITS);
                mul_a         = diff_abs;
                mul_b         = MUL_B_BITS'(alpha_reg) << (MUL_B_BITS - ALPHA_BITS);
            end
            ST_DI:
            begin
                mul_ctl.start = 1'b1;
                mul_ctl.len   = MUL_LEN_BITS'(GAIN_BITS);
                mul_a         = F_BITS'(di);
                mul_b         = MUL_B_BITS'(gain_reg) << (MUL_B_BITS - GAIN_BITS);
            end
            default: ;
        endcase
    end

    ebrd_mul #(
        .A_BITS (F_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .sts   (mul_sts)
    );

    ebrd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rate_num_reg),
        .den   (samp_cnt_reg),
        .quot  (div_quot),
        .sts   (div_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            filt_reg     <= '0;
            samp_cnt_reg <= '0;
            refr_cnt_reg <= '0;
            rate_reg     <= '0;
            x_reg        <= '0;
            sign_reg     <= 1'b0;
            old_int_reg  <= '0;
            deriv_reg    <= '0;
            beat_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_deriv_reg  <= '0;
            m_rate_reg   <= '0;
            m_beat_reg   <= 1'b0;
        end
        else
        begin
            // ST_OUT loads the output register itself
            if (m_tready && state_reg != ST_OUT)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        beat_reg  <= 1'b0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (mul_sts.done)
                    begin
                        x_reg     <= x_next;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    sign_reg  <= !x_ge;
                    state_reg <= ST_ALPHA;
                end
                ST_ALPHA:
                begin
                    if (mul_sts.done)
                    begin
                        old_int_reg <= filt_reg[F_BITS-1:FRAC_BITS];
                        filt_reg    <= filt_next;
                        state_reg   <= ST_DI;
                    end
                end
                ST_DI:
                begin
                    samp_cnt_reg <= samp_cnt_next;
                    refr_cnt_reg <= refr_cnt_next;
                    state_reg    <= ST_GAIN;
                end
                ST_GAIN:
                begin
                    if (mul_sts.done)
                    begin
                        deriv_reg <= deriv_next;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    state_reg <= beat_hit ? ST_DIV : ST_OUT;
                end
                ST_DIV:
                begin
                    if (div_sts.done)
                    begin
                        rate_reg     <= div_quot;
                        samp_cnt_reg <= '0;
                        refr_cnt_reg <= '0;
                        beat_reg     <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_deriv_reg <= deriv_reg;
                        m_rate_reg  <= rate_reg;
                        m_beat_reg  <= beat_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_rate_reg, m_deriv_reg});
    assign m_tuser  = m_beat_reg;

    `EBRD_ASSERT(a_ready_units_idle, s_tready, !mul_sts.busy && !div_sts.busy, "unit busy while ready")
    `EBRD_ASSERT(a_mul_done_in_wait, mul_sts.done, state_reg == ST_SQ || state_reg == ST_ALPHA || state_reg == ST_GAIN, "multiplier done outside a wait state")
    `EBRD_ASSERT(a_div_only_on_beat, div_sts.busy, state_reg == ST_DIV, "divider running outside beat path")
    `EBRD_ASSERT_NXT(a_beat_clears, state_reg == ST_DIV && div_sts.done, samp_cnt_reg == '0 && refr_cnt_reg == '0 && beat_reg, "beat did not clear counters")

endmodule
